// File: design/phx_pkg.sv
// Package: payload types, opcodes and constants for the Phelix decrypt/MAC core.
package phx_pkg;

    localparam logic [31:0] MAGIC_MAC_XOR = 32'h912D94F1;
    localparam int          NUM_CFG_REGS  = 5;

    typedef enum logic [1:0] {
        ACT_NONCE  = 2'd0,
        ACT_CIPHER = 2'd1,
        ACT_CHECK  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        CFG_KEY01 = 3'd0,
        CFG_KEY23 = 3'd1,
        CFG_KEY45 = 3'd2,
        CFG_KEY67 = 3'd3,
        CFG_BUMP  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  word_index;
        logic [31:0] data_word;
        logic [63:0] mac_low;
        logic [63:0] mac_high;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] plain_word;
        logic        mac_ok;
    } t_out_item;

    typedef logic [31:0] t_word;
    typedef t_word [4:0] t_mix;

    function automatic t_word rotl(input t_word x, input int r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction

endpackage

// File: design/phx_half_round.sv
// Shared half-round unit: one Phelix half-round over the five-word mixing state.
module phx_half_round (
    input  phx_pkg::t_mix  i_z,
    input  phx_pkg::t_word i_xa,
    input  phx_pkg::t_word i_xb,
    output phx_pkg::t_mix  o_z
);
    phx_pkg::t_word z0, z1, z2, z3, z4;

    always_comb begin
        z0 = i_z[0]; z1 = i_z[1]; z2 = i_z[2]; z3 = i_z[3]; z4 = i_z[4];
        z0 = z0 + (z3 ^ i_xa); z3 = phx_pkg::rotl(z3, 15);
        z1 = z1 + z4;          z4 = phx_pkg::rotl(z4, 25);
        z2 = z2 ^ z0;          z0 = phx_pkg::rotl(z0, 9);
        z3 = z3 ^ z1;          z1 = phx_pkg::rotl(z1, 10);
        z4 = z4 + z2;          z2 = phx_pkg::rotl(z2, 17);
        z0 = z0 ^ (z3 + i_xb); z3 = phx_pkg::rotl(z3, 30);
        z1 = z1 ^ z4;          z4 = phx_pkg::rotl(z4, 13);
        z2 = z2 + z0;          z0 = phx_pkg::rotl(z0, 20);
        z3 = z3 + z1;          z1 = phx_pkg::rotl(z1, 11);
        z4 = z4 ^ z2;          z2 = phx_pkg::rotl(z2, 5);
        o_z = {z4, z3, z2, z1, z0};
    end
endmodule

// File: design/phelix_decrypt_mac_core.sv
// Top level: Phelix-style decryptor with MAC check around one shared half-round unit.
// Each half-round passes through the single shared half-round unit. A ciphertext word
// runs a pair of half-rounds before its result is presented; setup after nonce word three
// runs the key-setup half-rounds and a MAC check runs the check half-rounds. Other nonce
// words are only stored. The input stalls while an item is in work or a result waits to
// be taken. Each transfer is taken in the idle state, so no new word is accepted before the last is done.
module phelix_decrypt_mac_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  phx_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output phx_pkg::t_out_item o_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);
    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} t_state;

    t_state          r_state;
    logic [63:0]     r_key [4];
    phx_pkg::t_word  r_bump;
    phx_pkg::t_mix   r_mix;
    phx_pkg::t_word  r_old [4];
    phx_pkg::t_word  r_rk [8];
    phx_pkg::t_word  r_ctr;
    phx_pkg::t_word  r_nonce [4];
    logic [1:0]      r_mode;      // ACT_NONCE = setup
    logic [4:0]      r_step;
    logic            r_phase;     // 0 first half-round, 1 second
    phx_pkg::t_word  r_plain;
    logic [127:0]    r_mac;
    logic            r_diff;
    phx_pkg::t_out_item r_out;

    phx_pkg::t_mix   hr_in, hr_out;
    phx_pkg::t_word  hr_xa, hr_xb, ks, plain;
    phx_pkg::t_word  kw_ctr, kw_step, rk_sel;
    logic            acc, last;
    logic [1:0]      mw;

    function automatic phx_pkg::t_word key_word(input logic [2:0] k,
                                                input logic [63:0] kr [4]);
        key_word = k[0] ? kr[k[2:1]][63:32] : kr[k[2:1]][31:0];
    endfunction

    phx_half_round u_hr (.i_z(hr_in), .i_xa(hr_xa), .i_xb(hr_xb), .o_z(hr_out));

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = (r_state == ST_OUT);
    assign o_data      = r_out;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign acc         = i_valid && !o_stall;

    assign kw_ctr  = key_word(r_ctr[2:0], r_key);
    assign kw_step = key_word(r_step[2:0], r_key);
    assign rk_sel  = r_rk[r_step[2:0]] + phx_pkg::t_word'(r_step[2:0]);
    assign ks      = hr_out[4] + r_old[r_ctr[1:0]];
    assign plain   = r_mac[31:0] ^ ks;
    assign mw      = 2'(r_step - 5'd8);

    always_comb begin
        hr_in = r_mix;
        hr_xa = '0;
        hr_xb = '0;
        if (r_mode == phx_pkg::ACT_NONCE) begin
            hr_xb = r_phase ? rk_sel : kw_step;
        end else if (!r_phase) begin
            hr_xb = kw_ctr;
        end else begin
            hr_xa = (r_mode == phx_pkg::ACT_CIPHER) ? r_plain : '0;
            hr_xb = r_rk[r_ctr[2:0]] + {r_ctr[31:3], 3'b000};
        end
        last = r_phase && (r_step == ((r_mode == phx_pkg::ACT_CHECK) ? 5'd11 : 5'd7)
                           || r_mode == phx_pkg::ACT_CIPHER);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int i = 0; i < 4; i++) begin
                r_key[i] <= '0;
                r_old[i] <= '0;
            end
            for (int i = 0; i < 8; i++) r_rk[i] <= '0;
            r_bump <= '0;
            r_mix  <= '0;
            r_ctr  <= '0;
            r_mode <= phx_pkg::ACT_NONCE;
            r_step <= '0;
            r_phase <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    phx_pkg::CFG_KEY01, phx_pkg::CFG_KEY23,
                    phx_pkg::CFG_KEY45, phx_pkg::CFG_KEY67: r_key[i_cfg_index[1:0]] <= i_cfg_data;
                    phx_pkg::CFG_BUMP: r_bump <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        r_mode  <= i_data.action;
                        r_step  <= '0;
                        r_phase <= 1'b0;
                        r_diff  <= 1'b0;
                        case (i_data.action)
                            phx_pkg::ACT_NONCE: begin
                                r_nonce[i_data.word_index] <= i_data.data_word;
                                if (i_data.word_index == 2'd3) begin
                                    for (int i = 0; i < 4; i++) begin
                                        phx_pkg::t_word n;
                                        n = (i == 3) ? i_data.data_word : r_nonce[i];
                                        r_rk[i]   <= key_word(3'(i + 4), r_key) + n
                                                     + ((i == 1) ? r_bump : '0);
                                        r_rk[i+4] <= key_word(3'(i), r_key)
                                                     + (phx_pkg::t_word'(i) - n)
                                                     + ((i == 1) ? r_bump : '0);
                                        r_mix[i]  <= key_word(3'(i + 3), r_key) ^ n;
                                    end
                                    r_mix[4] <= key_word(3'd7, r_key);
                                    r_state  <= ST_RUN;
                                end
                            end
                            phx_pkg::ACT_CIPHER: begin
                                r_mac[31:0] <= i_data.data_word;
                                r_state <= ST_RUN;
                            end
                            phx_pkg::ACT_CHECK: begin
                                r_mac    <= {i_data.mac_high, i_data.mac_low};
                                r_mix[0] <= r_mix[0] ^ phx_pkg::MAGIC_MAC_XOR;
                                r_state  <= ST_RUN;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RUN: begin
                    r_mix   <= hr_out;
                    r_phase <= !r_phase;
                    if (r_mode == phx_pkg::ACT_NONCE) begin
                        if (r_phase) begin
                            r_rk[r_step[2:0]]  <= rk_sel;
                            r_old[r_step[1:0]] <= hr_out[4];
                            r_step <= r_step + 5'd1;
                            if (last) begin
                                r_ctr   <= 32'd8;
                                r_state <= ST_IDLE;
                            end
                        end
                    end else if (!r_phase) begin
                        if (r_mode == phx_pkg::ACT_CIPHER) r_plain <= plain;
                        else if (r_step >= 5'd8 && ks != r_mac[32*mw +: 32]) r_diff <= 1'b1;
                    end else begin
                        r_old[r_ctr[1:0]] <= hr_out[4];
                        r_ctr  <= r_ctr + 32'd1;
                        r_step <= r_step + 5'd1;
                        if (last) begin
                            r_state <= ST_OUT;
                            if (r_mode == phx_pkg::ACT_CIPHER)
                                r_out <= '{result_kind: 1'b0, plain_word: r_plain, mac_ok: 1'b0};
                            else
                                r_out <= '{result_kind: 1'b1, plain_word: '0, mac_ok: !r_diff};
                        end
                    end
                end
                ST_OUT: begin
                    if (!i_stall) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
